/* rtl/cnlc_pkg.sv */
// Package for the card number Luhn classifier.
// Holds field widths, card class codes, the controller state type and the
// Luhn digit fold; used by every module under rtl.
`timescale 1ns / 1ps

package cnlc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned NUM_W   = 63;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned COUNT_W = 5;

  // Decimal digits needed for a 63-bit value, and their packed BCD width
  localparam int unsigned DIG_N  = 19;
  localparam int unsigned BCD_W  = 4 * DIG_N;
  localparam int unsigned SHFT_W = $clog2(NUM_W);
  localparam int unsigned IDX_W  = $clog2(DIG_N);

  localparam logic [SHFT_W-1:0] LAST_SHIFT = SHFT_W'(NUM_W - 1);
  localparam logic [IDX_W-1:0]  LAST_DIGIT = IDX_W'(DIG_N - 1);

  // Card class codes
  localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_AMEX    = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_VISA    = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_MASTER  = 2'd3;

  // Digit lengths that the classes require
  localparam logic [COUNT_W-1:0] LEN_AMEX = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16   = 5'd16;

  // Top-level controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN
  } cnlc_state_e;

  // One finished classification
  typedef struct packed {
    logic [CLASS_W-1:0] card_class;
    logic               luhn_ok;
    logic [COUNT_W-1:0] digit_count;
  } cnlc_res_t;

  // Double a digit and fold values of ten or more into n - 9
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] dd;
    dd = {d, 1'b0};
    if (dd >= 5'd10) begin
      dd = dd - 5'd9;
    end
    return dd[3:0];
  endfunction

endpackage

/* rtl/card_number_luhn_classifier.sv */
// Card number Luhn classifier. A result strobe follows each accepted start
// transaction; a new one is taken only in idle, after the last result.
// A 63-step binary to BCD shift-add-3 loop runs, then a 19-digit scan.
// busy stays high from acceptance until the result cycle ends; results
// cannot be stalled. Reset (rst_ni low, asynchronous) returns to idle.
`timescale 1ns / 1ps

module card_number_luhn_classifier
  import cnlc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [NUM_W-1:0]   card_number_i,
  output logic               valid_o,
  output logic [CLASS_W-1:0] card_class_o,
  output logic               luhn_ok_o,
  output logic [COUNT_W-1:0] digit_count_o
);

  cnlc_state_e      state_q, state_d;
  logic             conv_start;
  logic             conv_done;
  logic [BCD_W-1:0] bcd;
  logic             scan_done;
  cnlc_res_t        res;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start)     state_d = ST_CONV;
      ST_CONV: if (conv_done) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    busy       = (state_q != ST_IDLE);
    conv_start = (state_q == ST_IDLE) && start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  cnlc_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (card_number_i),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  cnlc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_done),
    .bcd_i   (bcd),
    .done_o  (scan_done),
    .res_o   (res)
  );

  assign valid_o       = scan_done;
  assign card_class_o  = res.card_class;
  assign luhn_ok_o     = res.luhn_ok;
  assign digit_count_o = res.digit_count;

  // A result only closes a scan in progress
  a_valid_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == ST_SCAN)
    else $error("result strobe outside scan");

  // Conversion finishes only while the controller waits for it
  a_conv_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == ST_CONV)
    else $error("conversion done outside conversion");

  // A classified card always passed the Luhn check
  a_class_needs_luhn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && card_class_o != CLASS_INVALID) |-> luhn_ok_o)
    else $error("card class without Luhn pass");

  // Digit count stays within one to nineteen
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (digit_count_o >= 5'd1 && digit_count_o <= 5'd19))
    else $error("digit count out of range");

  // Busy drops only after the result strobe
  a_busy_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(valid_o))
    else $error("busy released without result");

endmodule

/* rtl/cnlc_bcd.sv */
// Binary to BCD converter: shift-and-add-3, one input bit per cycle.
// Depends on cnlc_pkg for widths.
`timescale 1ns / 1ps

module cnlc_bcd
  import cnlc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] value_i,
  output logic             done_o,
  output logic [BCD_W-1:0] bcd_o
);

  logic [NUM_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  adj;
  logic [SHFT_W-1:0] cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < DIG_N; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                 : bcd_q[4*k +: 4];
    end
  end

  // Load on start, then shift one binary bit into the BCD word per cycle
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[NUM_W-1]};
      bin_d = {bin_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_SHIFT) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* rtl/cnlc_scan.sv */
// Digit scanner: walks the BCD digits from the right, one per cycle,
// keeping the Luhn sum mod ten, the digit count and the two leading digits.
// Depends on cnlc_pkg for widths, class codes and the Luhn fold.
`timescale 1ns / 1ps

module cnlc_scan
  import cnlc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BCD_W-1:0] bcd_i,
  output logic             done_o,
  output cnlc_res_t        res_o
);

  logic [BCD_W-1:0]   sh_q, sh_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               run_q, run_d;
  logic               fin_q, fin_d;
  logic               done_q;
  logic [3:0]         sum_q, sum_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]         first_q, first_d;
  logic [3:0]         second_q, second_d;
  logic [3:0]         prev_q, prev_d;
  cnlc_res_t          res_q, res_d;

  logic [3:0] dig;
  logic [3:0] term;
  logic [4:0] psum;

  // Fold every second digit from the right, accumulate mod ten
  assign dig  = sh_q[3:0];
  assign term = idx_q[0] ? luhn_double(dig) : dig;
  assign psum = {1'b0, sum_q} + {1'b0, term};

  // Advance one digit per cycle
  always_comb begin
    sh_d     = sh_q;
    idx_d    = idx_q;
    run_d    = run_q;
    fin_d    = 1'b0;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    second_d = second_q;
    prev_d   = prev_q;
    if (start_i) begin
      sh_d     = bcd_i;
      idx_d    = '0;
      run_d    = 1'b1;
      sum_d    = '0;
      cnt_d    = COUNT_W'(1);
      first_d  = '0;
      second_d = '0;
      prev_d   = '0;
    end else if (run_q) begin
      sh_d  = {4'd0, sh_q[BCD_W-1:4]};
      idx_d = idx_q + 1'b1;
      sum_d = (psum >= 5'd10) ? 4'(psum - 5'd10) : psum[3:0];
      // A nonzero digit is the leading one so far
      if (dig != 4'd0) begin
        cnt_d    = COUNT_W'(idx_q) + 1'b1;
        first_d  = dig;
        second_d = prev_q;
      end
      prev_d = dig;
      if (idx_q == LAST_DIGIT) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
  end

  // Classify from the finished totals
  always_comb begin
    res_d             = res_q;
    res_d.luhn_ok     = (sum_q == 4'd0);
    res_d.digit_count = cnt_q;
    res_d.card_class  = CLASS_INVALID;
    if (sum_q == 4'd0) begin
      if (cnt_q == LEN_AMEX && first_q == 4'd3 &&
          (second_q == 4'd4 || second_q == 4'd7)) begin
        res_d.card_class = CLASS_AMEX;
      end else if (cnt_q == LEN_16 && first_q == 4'd4) begin
        res_d.card_class = CLASS_VISA;
      end else if (cnt_q == LEN_16 && first_q == 4'd5 &&
                   second_q >= 4'd1 && second_q <= 4'd5) begin
        res_d.card_class = CLASS_MASTER;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      run_q  <= run_d;
      fin_q  <= fin_d;
      done_q <= fin_q;
    end
  end

  // Datapath registers; capture the result on the finish cycle
  always_ff @(posedge clk_i) begin
    sh_q     <= sh_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    second_q <= second_d;
    prev_q   <= prev_d;
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
